// ===== sv/fpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants of the requester/resource matcher
// Opcodes, result status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpm_pkg;

   localparam int ID_W     = 8;
   localparam int DIST_W   = 16;
   localparam int RATE_W   = 6;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = ID_W + DIST_W + RATE_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_REQ  = 2'd0,
      OP_ADD_RES  = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED      = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_DISPATCHED = 3'd2,
      STAT_NO_REQ     = 3'd3,
      STAT_NO_RES     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FREE_SCAN,
      ST_DISP_SCAN,
      ST_DISP_LAST,
      ST_DISP_END,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       fifo_push;
      logic       idx_clr;
      logic       idx_inc;
      logic       best_clr;
      logic       scan_rd;
      logic       slot_write;
      logic       pop;
      logic       set_res;
      status_type res_status;
      logic       load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      logic       fifo_full;
      logic       fifo_empty;
      logic       idx_last;
      logic       slot_free;
      logic       found;
   } stat_type;

endpackage

// ===== sv/fpm_ram.sv =====
// ----------------------------------------------------------------------------
// fpm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fpm_datapath.sv =====
// ----------------------------------------------------------------------------
// fpm_datapath: storage and compare logic of the matcher
// Holds the requester FIFO, the resource slot store with its valid bits,
// the slot scan with its running best candidate, and the result registers.
// ----------------------------------------------------------------------------
module fpm_datapath #(
   parameter int REQUEST_DEPTH  = 16,
   parameter int RESOURCE_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fpm_pkg::cmd_type              cmd,
   output fpm_pkg::stat_type             stat,
   input  logic [fpm_pkg::OP_W-1:0]      req_opcode,
   input  logic [fpm_pkg::ID_W-1:0]      req_agent_id,
   input  logic [fpm_pkg::DIST_W-1:0]    req_distance_m,
   input  logic [fpm_pkg::RATE_W-1:0]    req_rating_tenths,
   output logic [fpm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fpm_pkg::ID_W-1:0]      rsp_matched_requester,
   output logic [fpm_pkg::ID_W-1:0]      rsp_matched_resource
);

   localparam int RAW = $clog2(REQUEST_DEPTH);
   localparam int CNW = $clog2(REQUEST_DEPTH + 1);
   localparam int SAW = $clog2(RESOURCE_SLOTS);
   localparam logic [RAW-1:0] PTR_LAST  = RAW'(REQUEST_DEPTH - 1);
   localparam logic [CNW-1:0] CNT_FULL  = CNW'(REQUEST_DEPTH);
   localparam logic [SAW-1:0] IDX_LAST  = SAW'(RESOURCE_SLOTS - 1);

   // Captured request.
   fpm_pkg::opcode_type           op_ff;
   logic [fpm_pkg::ID_W-1:0]      id_ff;
   logic [fpm_pkg::DIST_W-1:0]    dist_ff;
   logic [fpm_pkg::RATE_W-1:0]    rate_ff;

   // Requester FIFO control.
   logic [RAW-1:0] head_ff, head_in;
   logic [RAW-1:0] tail_ff, tail_in;
   logic [CNW-1:0] count_ff, count_in;
   logic [fpm_pkg::ID_W-1:0] fifo_rdata;

   // Slot store.
   logic [RESOURCE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [SAW-1:0]            idx_ff, idx_in;
   logic [fpm_pkg::SLOT_W-1:0] slot_rdata;
   logic [fpm_pkg::ID_W-1:0]   rd_ident;
   logic [fpm_pkg::DIST_W-1:0] rd_dist;
   logic [fpm_pkg::RATE_W-1:0] rd_rate;

   // Scan pipeline and running best.
   logic                       cmp_en_ff;
   logic                       vld_d_ff;
   logic [SAW-1:0]             idx_d_ff;
   logic                       found_ff;
   logic [SAW-1:0]             best_idx_ff;
   logic [fpm_pkg::ID_W-1:0]   best_ident_ff;
   logic [fpm_pkg::DIST_W-1:0] best_dist_ff;
   logic [fpm_pkg::RATE_W-1:0] best_rate_ff;
   logic                       better;

   // Result staging and output registers.
   fpm_pkg::status_type        res_status_ff;
   logic [fpm_pkg::ID_W-1:0]   res_req_ff;
   logic [fpm_pkg::ID_W-1:0]   res_res_ff;
   fpm_pkg::status_type        out_status_ff;
   logic [fpm_pkg::ID_W-1:0]   out_req_ff;
   logic [fpm_pkg::ID_W-1:0]   out_res_ff;

   fpm_ram #(
      .WIDTH (fpm_pkg::ID_W),
      .DEPTH (REQUEST_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (cmd.fifo_push),
      .wr_addr (tail_ff),
      .wr_data (id_ff),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   fpm_ram #(
      .WIDTH (fpm_pkg::SLOT_W),
      .DEPTH (RESOURCE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.slot_write),
      .wr_addr (idx_ff),
      .wr_data ({id_ff, dist_ff, rate_ff}),
      .rd_addr (idx_ff),
      .rd_data (slot_rdata)
   );

   assign {rd_ident, rd_dist, rd_rate} = slot_rdata;

   // A slot wins on smaller distance, then on higher rating; on an exact tie
   // the earlier slot, seen first, is kept.
   always_comb begin
      better = !found_ff || (rd_dist < best_dist_ff) ||
               ((rd_dist == best_dist_ff) && (rd_rate > best_rate_ff));
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.fifo_push) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.slot_write) begin
         slot_valid_in[idx_ff] = 1'b1;
      end
      if (cmd.pop) begin
         slot_valid_in[best_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc && (idx_ff != IDX_LAST)) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         slot_valid_ff <= '0;
         idx_ff        <= '0;
         cmp_en_ff     <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         slot_valid_ff <= slot_valid_in;
         idx_ff        <= idx_in;
         cmp_en_ff     <= cmd.scan_rd;
         if (cmd.best_clr) begin
            found_ff <= 1'b0;
         end else if (cmp_en_ff && vld_d_ff && better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= fpm_pkg::opcode_type'(req_opcode);
         id_ff   <= req_agent_id;
         dist_ff <= req_distance_m;
         rate_ff <= req_rating_tenths;
      end
      vld_d_ff <= slot_valid_ff[idx_ff];
      idx_d_ff <= idx_ff;
      if (cmp_en_ff && vld_d_ff && better) begin
         best_idx_ff   <= idx_d_ff;
         best_ident_ff <= rd_ident;
         best_dist_ff  <= rd_dist;
         best_rate_ff  <= rd_rate;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_req_ff    <= cmd.pop ? fifo_rdata : '0;
         res_res_ff    <= cmd.pop ? best_ident_ff : '0;
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_req_ff    <= res_req_ff;
         out_res_ff    <= res_res_ff;
      end
   end

   always_comb begin
      stat.op         = op_ff;
      stat.fifo_full  = (count_ff == CNT_FULL);
      stat.fifo_empty = (count_ff == '0);
      stat.idx_last   = (idx_ff == IDX_LAST);
      stat.slot_free  = !slot_valid_ff[idx_ff];
      stat.found      = found_ff;
   end

   assign rsp_status            = out_status_ff;
   assign rsp_matched_requester = out_req_ff;
   assign rsp_matched_resource  = out_res_ff;

endmodule

// ===== sv/fpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpm_ctrl: controller of the matcher
// Sequences one request at a time through decode, slot scans and result
// hand-off, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module fpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fpm_pkg::stat_type stat,
   output fpm_pkg::cmd_type  cmd
);

   fpm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fpm_pkg::ST_DECODE;
            end
         end
         fpm_pkg::ST_DECODE: begin
            case (stat.op)
               fpm_pkg::OP_ADD_REQ: state_in = fpm_pkg::ST_RESP;
               fpm_pkg::OP_ADD_RES: state_in = fpm_pkg::ST_FREE_SCAN;
               fpm_pkg::OP_DISPATCH: begin
                  state_in = stat.fifo_empty ? fpm_pkg::ST_RESP : fpm_pkg::ST_DISP_SCAN;
               end
               default: state_in = fpm_pkg::ST_IDLE;
            endcase
         end
         fpm_pkg::ST_FREE_SCAN: begin
            if (stat.slot_free || stat.idx_last) begin
               state_in = fpm_pkg::ST_RESP;
            end
         end
         fpm_pkg::ST_DISP_SCAN: begin
            if (stat.idx_last) begin
               state_in = fpm_pkg::ST_DISP_LAST;
            end
         end
         fpm_pkg::ST_DISP_LAST: state_in = fpm_pkg::ST_DISP_END;
         fpm_pkg::ST_DISP_END:  state_in = fpm_pkg::ST_RESP;
         fpm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = fpm_pkg::ST_IDLE;
            end
         end
         default: state_in = fpm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = fpm_pkg::STAT_ADDED;
      req_ready      = 1'b0;
      case (state_ff)
         fpm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         fpm_pkg::ST_DECODE: begin
            case (stat.op)
               fpm_pkg::OP_ADD_REQ: begin
                  cmd.set_res    = 1'b1;
                  cmd.fifo_push  = !stat.fifo_full;
                  cmd.res_status = stat.fifo_full ? fpm_pkg::STAT_FULL : fpm_pkg::STAT_ADDED;
               end
               fpm_pkg::OP_ADD_RES: begin
                  cmd.idx_clr = 1'b1;
               end
               fpm_pkg::OP_DISPATCH: begin
                  cmd.set_res    = stat.fifo_empty;
                  cmd.res_status = fpm_pkg::STAT_NO_REQ;
                  cmd.idx_clr    = 1'b1;
                  cmd.best_clr   = 1'b1;
               end
               default: ;
            endcase
         end
         fpm_pkg::ST_FREE_SCAN: begin
            if (stat.slot_free) begin
               cmd.slot_write = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.res_status = fpm_pkg::STAT_ADDED;
            end else if (stat.idx_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = fpm_pkg::STAT_FULL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         fpm_pkg::ST_DISP_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         fpm_pkg::ST_DISP_END: begin
            cmd.set_res    = 1'b1;
            cmd.pop        = stat.found;
            cmd.res_status = stat.found ? fpm_pkg::STAT_DISPATCHED : fpm_pkg::STAT_NO_RES;
         end
         fpm_pkg::ST_RESP: begin
            cmd.load_out = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/fifo_to_priority_matcher.sv =====
// ----------------------------------------------------------------------------
// fifo_to_priority_matcher: pairs queued requesters with the best resource
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on the req_ channel carries an opcode: add requester
//   (queued in a FIFO of REQUEST_DEPTH entries), add resource (stored in the
//   lowest free of RESOURCE_SLOTS slots) or dispatch (pops the oldest
//   requester and takes the slot with the least distance, then the highest
//   rating, then the lowest slot). Each of these gives one beat on the rsp_
//   channel; the unused opcode gives none.
//   Items are processed one at a time. Add requester is decided in decode;
//   add resource scans from the lowest slot past the occupied slots ahead of
//   the first free one, and a dispatch that finds requesters scans every
//   slot, one slot per cycle through the single read port of the slot
//   memory, before the result register is set. The next request is accepted
//   once that result has gone on to the output register.
//   Reset empties the FIFO and frees every slot.
//   When the receiver stalls, the result waits in the output register and the
//   next request is still accepted; its result is held back until the
//   earlier one has been taken.
// ----------------------------------------------------------------------------
module fifo_to_priority_matcher #(
   parameter int REQUEST_DEPTH  = 16,
   parameter int RESOURCE_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fpm_pkg::OP_W-1:0]      req_opcode,
   input  logic [fpm_pkg::ID_W-1:0]      req_agent_id,
   input  logic [fpm_pkg::DIST_W-1:0]    req_distance_m,
   input  logic [fpm_pkg::RATE_W-1:0]    req_rating_tenths,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fpm_pkg::ID_W-1:0]      rsp_matched_requester,
   output logic [fpm_pkg::ID_W-1:0]      rsp_matched_resource
);

   fpm_pkg::cmd_type  cmd;
   fpm_pkg::stat_type stat;

   fpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpm_datapath #(
      .REQUEST_DEPTH  (REQUEST_DEPTH),
      .RESOURCE_SLOTS (RESOURCE_SLOTS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_opcode            (req_opcode),
      .req_agent_id          (req_agent_id),
      .req_distance_m        (req_distance_m),
      .req_rating_tenths     (req_rating_tenths),
      .rsp_status            (rsp_status),
      .rsp_matched_requester (rsp_matched_requester),
      .rsp_matched_resource  (rsp_matched_resource)
   );

   // A push never goes into a full FIFO.
   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      cmd.fifo_push |-> !stat.fifo_full)
      else $error("requester pushed into a full FIFO");

   // A pop needs a queued requester and a chosen slot.
   a_pop_legal : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (stat.found && !stat.fifo_empty))
      else $error("dispatch popped without requester or resource");

   // Only one item is in work at a time.
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

   // Loading the output register always presents a beat.
   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result loaded but not presented");

endmodule

// ===== tb/tb_fifo_to_priority_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_to_priority_matcher: self-checking bench for the request matcher
// Drives directed and random opcode streams through the req_ channel, keeps
// its own model of the requester FIFO and the resource slots, and compares
// every rsp_ beat field by field, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_fifo_to_priority_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CLK_PERIOD = 10;
   localparam int  REQ_DEPTH  = 16;
   localparam int  SLOT_COUNT = 16;
   localparam int  RANDOM_BEATS = 1400;
   localparam int  DRAIN_CYCLES = 3 * (SLOT_COUNT + 5);
   localparam int  ID_W     = fpm_pkg::ID_W;
   localparam int  DIST_W   = fpm_pkg::DIST_W;
   localparam int  RATE_W   = fpm_pkg::RATE_W;
   localparam int  OP_W     = fpm_pkg::OP_W;
   localparam int  STATUS_W = fpm_pkg::STATUS_W;

   typedef struct {
      fpm_pkg::opcode_type op;
      logic [ID_W-1:0]     agent;
      logic [DIST_W-1:0]   meters;
      logic [RATE_W-1:0]   rating;
   } req_beat_type;

   typedef struct {
      fpm_pkg::status_type status;
      logic [ID_W-1:0]     requester;
      logic [ID_W-1:0]     resource;
   } match_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [ID_W-1:0]     req_agent_id = '0;
   logic [DIST_W-1:0]   req_distance_m = '0;
   logic [RATE_W-1:0]   req_rating_tenths = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_matched_requester;
   logic [ID_W-1:0]     rsp_matched_resource;

   // Predictor state: waiting requesters in arrival order and the slot table.
   logic [ID_W-1:0]     waiting_requesters[$];
   logic                slot_used[SLOT_COUNT];
   logic [ID_W-1:0]     slot_agent[SLOT_COUNT];
   logic [DIST_W-1:0]   slot_dist[SLOT_COUNT];
   logic [RATE_W-1:0]   slot_rate[SLOT_COUNT];

   req_beat_type        req_backlog[$];
   req_beat_type        next_beat;
   match_type           match_results_due[$];
   match_type           due;
   match_type           want;
   logic                req_fire = 1'b0;
   int                  total_beats = 0;
   int                  accepted_cnt = 0;
   int                  rsp_cnt = 0;
   int                  mismatches = 0;
   int                  status_hits[5] = '{default: 0};
   int                  unused_cnt = 0;

   fifo_to_priority_matcher #(
      .REQUEST_DEPTH (REQ_DEPTH),
      .RESOURCE_SLOTS(SLOT_COUNT)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_agent_id         (req_agent_id),
      .req_distance_m       (req_distance_m),
      .req_rating_tenths    (req_rating_tenths),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_matched_requester(rsp_matched_requester),
      .rsp_matched_resource (rsp_matched_resource)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Returns 1 when the beat produces a result, and that result in m.
   function automatic bit predict_match(input fpm_pkg::opcode_type op,
                                        input logic [ID_W-1:0] agent,
                                        input logic [DIST_W-1:0] meters,
                                        input logic [RATE_W-1:0] rating,
                                        output match_type m);
      int best;
      m = '{status: fpm_pkg::STAT_ADDED, requester: '0, resource: '0};
      best = -1;
      case (op)
         fpm_pkg::OP_ADD_REQ: begin
            if (waiting_requesters.size() >= REQ_DEPTH) begin
               m.status = fpm_pkg::STAT_FULL;
            end else begin
               waiting_requesters = {waiting_requesters, agent};
            end
         end
         fpm_pkg::OP_ADD_RES: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (best < 0 && !slot_used[i]) best = i;
            end
            if (best < 0) begin
               m.status = fpm_pkg::STAT_FULL;
            end else begin
               slot_used[best]  = 1'b1;
               slot_agent[best] = agent;
               slot_dist[best]  = meters;
               slot_rate[best]  = rating;
            end
         end
         fpm_pkg::OP_DISPATCH: begin
            // The requester check wins over the resource check.
            if (waiting_requesters.size() == 0) begin
               m.status = fpm_pkg::STAT_NO_REQ;
            end else begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_used[i] && (best < 0 || slot_dist[i] < slot_dist[best] ||
                      (slot_dist[i] == slot_dist[best] && slot_rate[i] > slot_rate[best])))
                     best = i;
               end
               if (best < 0) begin
                  m.status = fpm_pkg::STAT_NO_RES;
               end else begin
                  m.status        = fpm_pkg::STAT_DISPATCHED;
                  m.requester     = waiting_requesters.pop_front();
                  m.resource      = slot_agent[best];
                  slot_used[best] = 1'b0;
               end
            end
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic int idle_phase();
      int p;
      p = (total_beats == 0) ? 0 : (accepted_cnt * 4) / total_beats;
      return (p > 3) ? 3 : p;
   endfunction

   function automatic int send_idle_pct();
      case (idle_phase())
         1:       return 52;
         3:       return 26;
         default: return 0;
      endcase
   endfunction

   function automatic int rsp_stall_pct();
      case (idle_phase())
         2:       return 52;
         3:       return 26;
         default: return 0;
      endcase
   endfunction

   task automatic queue_beat(input fpm_pkg::opcode_type op, input int agent,
                             input int meters, input int rating);
      req_beat_type b;
      b.op     = op;
      b.agent  = agent[ID_W-1:0];
      b.meters = meters[DIST_W-1:0];
      b.rating = rating[RATE_W-1:0];
      req_backlog = {req_backlog, b};
   endtask

   // Driver: a new beat is presented only when the line is free or was just taken.
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
            next_beat = req_backlog.pop_front();
            req_valid         <= 1'b1;
            req_opcode        <= next_beat.op;
            req_agent_id      <= next_beat.agent;
            req_distance_m    <= next_beat.meters;
            req_rating_tenths <= next_beat.rating;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct());
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted_cnt++;
            if (predict_match(fpm_pkg::opcode_type'(req_opcode), req_agent_id,
                              req_distance_m, req_rating_tenths, due)) begin
               match_results_due = {match_results_due, due};
               status_hits[due.status]++;
            end else begin
               unused_cnt++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            rsp_cnt++;
            if (match_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: unexpected beat status %0d requester %0d resource %0d",
                           rsp_cnt, rsp_status, rsp_matched_requester, rsp_matched_resource);
            end else begin
               want = match_results_due.pop_front();
               if (rsp_status !== want.status || rsp_matched_requester !== want.requester ||
                   rsp_matched_resource !== want.resource) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d: expected status %0d requester %0d resource %0d,",
                               " got status %0d requester %0d resource %0d"},
                              rsp_cnt, want.status, want.requester, want.resource,
                              rsp_status, rsp_matched_requester, rsp_matched_resource);
               end
            end
         end
      end
   end

   initial begin
      int mode;
      int burst;
      int made;
      int r;
      int t_unused;
      int t_req;
      int t_res;
      int meters;
      int rating;

      for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty-store dispatches, field extremes, ties, unused opcode.
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_ADD_RES, 0, 0, 10);
      queue_beat(fpm_pkg::OP_DISPATCH, 255, 65535, 63);
      queue_beat(fpm_pkg::OP_ADD_REQ, 255, 0, 0);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_ADD_REQ, 0, 65535, 63);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_UNUSED, 255, 65535, 63);
      queue_beat(fpm_pkg::OP_ADD_RES, 255, 65535, 63);
      queue_beat(fpm_pkg::OP_ADD_RES, 170, 65535, 0);
      queue_beat(fpm_pkg::OP_ADD_RES, 85, 65535, 63);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_ADD_REQ, 1, 0, 0);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_ADD_RES, 42, 65535, 50);
      queue_beat(fpm_pkg::OP_ADD_RES, 43, 65534, 10);
      queue_beat(fpm_pkg::OP_ADD_REQ, 128, 0, 0);
      queue_beat(fpm_pkg::OP_ADD_REQ, 127, 0, 0);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_DISPATCH, 0, 0, 0);
      queue_beat(fpm_pkg::OP_UNUSED, 0, 0, 0);

      // Random part in bursts that lean toward filling one store or draining both,
      // so that both full conditions and both empty conditions recur.
      made = 0;
      while (made < RANDOM_BEATS) begin
         mode  = $urandom_range(3);
         burst = $urandom_range(60, 20);
         case (mode)
            1:       begin t_unused = 2; t_req = 70; t_res = 85; end
            2:       begin t_unused = 2; t_req = 15; t_res = 85; end
            3:       begin t_unused = 2; t_req = 12; t_res = 24; end
            default: begin t_unused = 3; t_req = 37; t_res = 68; end
         endcase
         for (int k = 0; k < burst && made < RANDOM_BEATS; k++) begin
            case ($urandom_range(3))
               0:       meters = $urandom_range(3);
               1:       meters = 65535 - $urandom_range(1);
               default: meters = $urandom_range(65535);
            endcase
            case ($urandom_range(4))
               0:       rating = $urandom_range(63);
               1:       rating = $urandom_range(1) ? 50 : 10;
               default: rating = $urandom_range(50, 10);
            endcase
            r = $urandom_range(99);
            if (r < t_unused) begin
               queue_beat(fpm_pkg::OP_UNUSED, $urandom_range(255), meters, rating);
            end else begin
               if (r < t_req)
                  queue_beat(fpm_pkg::OP_ADD_REQ, $urandom_range(255), meters, rating);
               else if (r < t_res)
                  queue_beat(fpm_pkg::OP_ADD_RES, $urandom_range(255), meters, rating);
               else
                  queue_beat(fpm_pkg::OP_DISPATCH, $urandom_range(255), meters, rating);
               made++;
            end
         end
      end
      total_beats = req_backlog.size();

      while (accepted_cnt < total_beats) @(negedge clock);
      while (match_results_due.size() != 0) @(negedge clock);
      // Catch any stray beat after the last expected one.
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d beats (%0d with the unused opcode), checked %0d results.",
               accepted_cnt, unused_cnt, rsp_cnt);
      $display("Dispatched %0d, store full %0d, no requester %0d, no resource %0d, added %0d.",
               status_hits[fpm_pkg::STAT_DISPATCHED], status_hits[fpm_pkg::STAT_FULL],
               status_hits[fpm_pkg::STAT_NO_REQ], status_hits[fpm_pkg::STAT_NO_RES],
               status_hits[fpm_pkg::STAT_ADDED]);
      if (mismatches == 0 && match_results_due.size() == 0) begin
         $display("fifo_to_priority_matcher: match");
      end else begin
         $display("fifo_to_priority_matcher: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d of %0d beats accepted.", accepted_cnt, total_beats);
      $display("fifo_to_priority_matcher: mismatch");
      $finish;
   end

endmodule
